// ===== src/msns_pkg.sv =====
// ----------------------------------------------------------------------------
// msns_pkg: shared types and constants of the markov next-symbol sampler
// Table geometry, field widths and the table port bundles.
// ----------------------------------------------------------------------------
package msns_pkg;

  localparam int ALPHABET_SIZE = 94;
  localparam int FRACTION_BITS = 20;

  // field widths fixed by the interface
  localparam int SYM_W   = 7;
  localparam int ENTRY_W = FRACTION_BITS + 1;
  localparam int DRAW_W  = FRACTION_BITS;

  localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(ALPHABET_SIZE + 1);
  // running sum of a full row never overflows
  localparam int SUM_W       = ENTRY_W + $clog2(ALPHABET_SIZE);

  localparam logic [0:0] OP_WRITE  = 1'b0;
  localparam logic [0:0] OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

endpackage

// ===== src/msns_table.sv =====
// ----------------------------------------------------------------------------
// msns_table: transition probability store
// One write port and one registered read port; contents undefined at reset.
// ----------------------------------------------------------------------------
module msns_table (
  input  logic                          clk,
  input  msns_pkg::tbl_wr_t             wr,
  input  msns_pkg::tbl_rd_t             rd,
  output logic [msns_pkg::ENTRY_W-1:0]  rd_data
);
  import msns_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/markov_next_symbol_sampler.sv =====
// ----------------------------------------------------------------------------
// markov_next_symbol_sampler: inverse-cdf next-symbol sampler
// Walks one row of the probability table, one entry a cycle, through a
// shared accumulate/compare unit.
// ----------------------------------------------------------------------------
// a table write gives no result; busy stays low
// a sample stays busy until the walk stops at a column, at most the last one,
// with one table read and one accumulate per cycle; the strobe follows
// a sample of a row beyond the alphabet gives its result the next cycle
// results are strobed for one cycle; the receiver cannot stall
// reset clears control and the mode register; table contents stay undefined
module markov_next_symbol_sampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [msns_pkg::SYM_W-1:0]          in_current_symbol,
  input  logic [msns_pkg::SYM_W-1:0]          in_column_symbol,
  input  logic [msns_pkg::ENTRY_W-1:0]        in_entry_probability,
  input  logic [msns_pkg::DRAW_W-1:0]         in_uniform_draw,
  output logic                                out_valid,
  output logic [msns_pkg::SYM_W-1:0]          out_next_symbol,
  output logic                                out_found,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_pick_most_likely
);
  import msns_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  localparam logic [SYM_W:0]    SYM_COUNT  = (SYM_W + 1)'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0]  LAST_COL   = SYM_W'(ALPHABET_SIZE - 1);
  localparam logic [CNT_W-1:0]  COL_END    = CNT_W'(ALPHABET_SIZE);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(ALPHABET_SIZE);

  state_t              state_r, state_nxt;
  logic                mode_r, mode_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    issue_col_r, issue_col_nxt;
  logic                data_vld_r, data_vld_nxt;
  logic [SYM_W-1:0]    data_col_r, data_col_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ENTRY_W-1:0]  best_r, best_nxt;
  logic [SYM_W-1:0]    pick_r, pick_nxt;
  logic                hit_r, hit_nxt;
  logic [DRAW_W-1:0]   draw_r, draw_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]    out_sym_r, out_sym_nxt;
  logic                out_found_r, out_found_nxt;

  tbl_wr_t             tbl_wr;
  tbl_rd_t             tbl_rd;
  logic [ENTRY_W-1:0]  rd_data;

  logic                accept;
  logic                row_ok;
  logic                col_ok;
  logic [ADDR_W-1:0]   row_base;
  logic [SUM_W-1:0]    acc;
  logic                below;
  logic                larger;
  logic                finish;

  assign accept   = start && !busy;
  assign row_ok   = {1'b0, in_current_symbol} < SYM_COUNT;
  assign col_ok   = {1'b0, in_column_symbol} < SYM_COUNT;
  assign row_base = ADDR_W'(in_current_symbol) * ROW_STRIDE;

  assign tbl_wr.en   = accept && (in_operation == OP_WRITE) && row_ok && col_ok;
  assign tbl_wr.addr = row_base + ADDR_W'(in_column_symbol);
  assign tbl_wr.data = in_entry_probability;

  // shared unit: running sum and draw compare, or running maximum
  assign acc    = sum_r + SUM_W'(rd_data);
  assign below  = SUM_W'(draw_r) < acc;
  assign larger = rd_data > best_r;
  assign finish = (state_r == ST_WALK) && data_vld_r &&
                  ((!mode_r && below) || (data_col_r == LAST_COL));

  assign tbl_rd.en   = (state_r == ST_WALK) && (issue_col_r != COL_END) && !finish;
  assign tbl_rd.addr = addr_r;

  msns_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    issue_col_nxt = issue_col_r;
    data_vld_nxt  = tbl_rd.en;
    data_col_nxt  = SYM_W'(issue_col_r);
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    hit_nxt       = hit_r;
    draw_nxt      = draw_r;
    out_valid_nxt = 1'b0;
    out_sym_nxt   = out_sym_r;
    out_found_nxt = out_found_r;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_pick_most_likely;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_SAMPLE)) begin
          if (row_ok) begin
            state_nxt     = ST_WALK;
            addr_nxt      = row_base;
            issue_col_nxt = '0;
            sum_nxt       = '0;
            best_nxt      = '0;
            pick_nxt      = '0;
            hit_nxt       = 1'b0;
            draw_nxt      = in_uniform_draw;
          end else begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = '0;
            out_found_nxt = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (tbl_rd.en) begin
          addr_nxt      = addr_r + ADDR_W'(1);
          issue_col_nxt = issue_col_r + CNT_W'(1);
        end
        if (data_vld_r) begin
          sum_nxt = acc;
          if (larger) begin
            best_nxt = rd_data;
            pick_nxt = data_col_r;
            hit_nxt  = 1'b1;
          end
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!mode_r) begin
            out_found_nxt = below;
            out_sym_nxt   = below ? data_col_r : '0;
          end else begin
            out_found_nxt = hit_r || larger;
            out_sym_nxt   = larger ? data_col_r : pick_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      data_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_sym_r   <= '0;
      out_found_r <= 1'b0;
      issue_col_r <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      data_vld_r  <= data_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_sym_r   <= out_sym_nxt;
      out_found_r <= out_found_nxt;
      issue_col_r <= issue_col_nxt;
    end
    addr_r     <= addr_nxt;
    data_col_r <= data_col_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    hit_r      <= hit_nxt;
    draw_r     <= draw_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = !busy;
  assign out_valid       = out_valid_r;
  assign out_next_symbol = out_sym_r;
  assign out_found       = out_found_r;

`ifndef SYNTH
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_next_symbol == '0)
    else $error("result without a symbol carries a nonzero index");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == OP_WRITE) |=> !out_valid)
    else $error("write request produced a result");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && data_vld_r |-> {1'b0, data_col_r} < SYM_COUNT)
    else $error("walk processed a column beyond the row");

  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> issue_col_r <= COL_END)
    else $error("read column counter ran past the row");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> !data_vld_r)
    else $error("table read in flight after leaving the walk");
`endif

endmodule
